>>> hdl/lpsht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpsht_pkg
// Types and codes used by the string hash table.
// ----------------------------------------------------------------------------
package lpsht_pkg;

	// The table size must stay a power of two: the home bucket is taken from
	// the low bits of the character sum.
	localparam int TABLE_SIZE    = 16;
	localparam int MAX_KEY_CHARS = 16;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_FOUND    = 3'd1;
	localparam logic [2:0] ST_ABSENT   = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_TOO_LONG = 3'd4;
	localparam logic [2:0] ST_CLEARED  = 3'd5;

	localparam int STATUS_W = 3;
	localparam int BUCKET_W = 4;

endpackage
`default_nettype wire

>>> hdl/linear_probe_string_hash_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_string_hash_table
// String-keyed hash table with linear probing and optional replacement.
// ----------------------------------------------------------------------------
// Key characters are taken one per cycle while busy is low; a character word
// gives no result. The final word starts a walk through the bucket memories,
// or goes straight to a too-long result. A search reads the header of every
// bucket visited and, when the lengths agree, compares the stored characters
// one by one. An insert steps from the home bucket to the first free one,
// reads the header of the home bucket when it is occupied, moves the occupant
// to the free bucket when replacement is on and the occupant is not at its
// own home (all MAX_KEY_CHARS are copied), and then writes the characters of
// the key. The worst case is a search that compares a full-length key in every
// bucket. Clear keeps busy high through S_CLR, which zeroes the occupancy
// bits, and S_DONE. Each result appears on done for one cycle, the first
// cycle after busy falls, and cannot be stalled by the receiver, so it must
// be captured when shown.
module linear_probe_string_hash_table (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [1:0]                          operation,
	input  wire logic [7:0]                          char_code,
	input  wire logic                                last_char,
	input  wire logic                                cfg_we,
	input  wire logic                                cfg_wdata,
	output logic                                     done,
	output logic [lpsht_pkg::STATUS_W-1:0]           status,
	output logic [lpsht_pkg::BUCKET_W-1:0]           bucket,
	output logic                                     displaced,
	output logic [lpsht_pkg::BUCKET_W-1:0]           moved_to
);
	import lpsht_pkg::*;

	localparam int TW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int CW = (MAX_KEY_CHARS > 1) ? $clog2(MAX_KEY_CHARS) : 1;
	localparam int LW = $clog2(MAX_KEY_CHARS + 1);
	localparam int AW = TW + CW;
	localparam int SW = LW + 8;
	localparam int HW = LW + TW;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_HREQ   = 10'b0000000010,
		S_HCHK   = 10'b0000000100,
		S_CMP    = 10'b0000001000,
		S_FREE   = 10'b0000010000,
		S_MOVE   = 10'b0000100000,
		S_MOVEWR = 10'b0001000000,
		S_PUT    = 10'b0010000000,
		S_CLR    = 10'b0100000000,
		S_DONE   = 10'b1000000000
	} state_t;

	state_t state_q;
	logic mode_q;
	logic [TABLE_SIZE-1:0] used_q;
	logic [LW-1:0] klen_q;
	logic [SW-1:0] ksum_q;
	logic kovf_q;
	logic is_ins_q;
	logic [TW-1:0] home_q, probe_q, dest_q, free_q;
	logic [TW:0] cnt_q;
	logic [CW-1:0] ci_q;
	logic mv_q;
	logic [HW-1:0] occ_hd_q;

	logic [STATUS_W-1:0] st_q;
	logic [BUCKET_W-1:0] bk_q, mt_q;
	logic dp_q, done_q;

	// Memories: key buffer, stored characters, stored length and home.
	logic kb_we;
	logic [CW-1:0] kb_waddr, kb_raddr;
	logic [7:0] kb_rdata;
	logic bc_we;
	logic [AW-1:0] bc_waddr, bc_raddr;
	logic [7:0] bc_wdata, bc_rdata;
	logic hd_we;
	logic [TW-1:0] hd_waddr, hd_raddr;
	logic [HW-1:0] hd_wdata, hd_rdata;

	lpsht_ram #(.WIDTH(8), .DEPTH(1 << CW)) u_kbuf (
		.clk(clk), .we(kb_we), .waddr(kb_waddr), .wdata(char_code),
		.raddr(kb_raddr), .rdata(kb_rdata));
	lpsht_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_chars (
		.clk(clk), .we(bc_we), .waddr(bc_waddr), .wdata(bc_wdata),
		.raddr(bc_raddr), .rdata(bc_rdata));
	lpsht_ram #(.WIDTH(HW), .DEPTH(1 << TW)) u_head (
		.clk(clk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
		.raddr(hd_raddr), .rdata(hd_rdata));

	logic [LW-1:0] hd_len;
	logic [TW-1:0] hd_home;
	assign hd_len  = hd_rdata[HW-1:TW];
	assign hd_home = hd_rdata[TW-1:0];

	logic accept;
	assign accept = start && !busy;
	assign busy = (state_q != S_IDLE);

	function automatic logic [TW-1:0] wrap_inc(input logic [TW-1:0] b);
		logic [TW:0] n;
		n = {1'b0, b} + 1'b1;
		return (n == (TW + 1)'(TABLE_SIZE)) ? '0 : n[TW-1:0];
	endfunction

	// The table size is a power of two, so the home bucket is simply the low
	// bits of the running character sum.
	logic [TW-1:0] home_c;
	logic [SW-1:0] sum_next;
	assign sum_next = ksum_q + SW'(char_code);
	assign home_c = sum_next[TW-1:0];

	logic last_cmp;
	assign last_cmp = ({1'b0, ci_q} + 1'b1) == (CW + 1)'(klen_q);

	always_comb begin
		kb_we    = accept && (operation == OP_INSERT || operation == OP_SEARCH)
			&& (klen_q < LW'(MAX_KEY_CHARS));
		kb_waddr = klen_q[CW-1:0];
		kb_raddr = ci_q;
		bc_we    = 1'b0;
		bc_waddr = {probe_q, ci_q};
		bc_wdata = kb_rdata;
		bc_raddr = {probe_q, ci_q};
		hd_we    = 1'b0;
		hd_waddr = probe_q;
		hd_wdata = {klen_q, home_q};
		hd_raddr = probe_q;
		unique case (state_q)
			S_MOVEWR: begin
				bc_we    = mv_q;
				bc_waddr = {free_q, ci_q};
				bc_wdata = bc_rdata;
				bc_raddr = {home_q, ci_q};
				// The moved occupant keeps its own length and home.
				hd_we    = mv_q && (ci_q == CW'(MAX_KEY_CHARS - 1));
				hd_waddr = free_q;
				hd_wdata = occ_hd_q;
			end
			S_MOVE: begin
				bc_raddr = {home_q, ci_q};
				hd_raddr = home_q;
			end
			S_PUT: begin
				bc_we    = mv_q && (klen_q != '0);
				bc_waddr = {dest_q, ci_q};
				hd_we    = last_cmp || (klen_q == '0);
				hd_waddr = dest_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mode_q   <= 1'b0;
			used_q   <= '0;
			klen_q   <= '0;
			ksum_q   <= '0;
			kovf_q   <= 1'b0;
			is_ins_q <= 1'b0;
			home_q   <= '0;
			probe_q  <= '0;
			dest_q   <= '0;
			free_q   <= '0;
			occ_hd_q <= '0;
			st_q     <= '0;
			bk_q     <= '0;
			mt_q     <= '0;
			dp_q     <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
			ci_q     <= '0;
			mv_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && operation == OP_CLEAR) begin
						state_q <= S_CLR;
					end else if (accept && operation != OP_NONE) begin
						if (klen_q < LW'(MAX_KEY_CHARS)) begin
							klen_q <= klen_q + 1'b1;
							ksum_q <= sum_next;
						end else begin
							kovf_q <= 1'b1;
						end
						if (last_char) begin
							is_ins_q <= (operation == OP_INSERT);
							mv_q     <= 1'b0;
							dp_q     <= 1'b0;
							mt_q     <= '0;
							bk_q     <= '0;
							cnt_q    <= '0;
							ci_q     <= '0;
							// A key is too long if it overflowed earlier or with this word.
							if (kovf_q || klen_q >= LW'(MAX_KEY_CHARS)) begin
								st_q    <= ST_TOO_LONG;
								state_q <= S_DONE;
							end else begin
								state_q <= S_HREQ;
							end
							home_q  <= home_c;
							probe_q <= home_c;
						end
					end
				end
				S_HREQ: begin
					// header read of probe_q issued this cycle
					state_q <= S_HCHK;
					if (is_ins_q) begin
						state_q <= S_FREE;
						free_q  <= home_q;
					end
				end
				S_HCHK: begin
					if (!used_q[probe_q] || cnt_q == (TW + 1)'(TABLE_SIZE)) begin
						st_q    <= ST_ABSENT;
						state_q <= S_DONE;
					end else if (hd_len == klen_q) begin
						ci_q    <= '0;
						state_q <= (klen_q == '0) ? S_DONE : S_CMP;
						if (klen_q == '0) begin
							st_q <= ST_FOUND;
							bk_q <= BUCKET_W'(probe_q);
						end
					end else begin
						probe_q <= wrap_inc(probe_q);
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_HREQ;
					end
				end
				S_CMP: begin
					// both reads for ci_q arrive in the cycle after issue
					if (!mv_q) begin
						mv_q <= 1'b1;
					end else if (bc_rdata != kb_rdata) begin
						mv_q    <= 1'b0;
						probe_q <= wrap_inc(probe_q);
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_HREQ;
					end else if (last_cmp) begin
						mv_q    <= 1'b0;
						st_q    <= ST_FOUND;
						bk_q    <= BUCKET_W'(probe_q);
						state_q <= S_DONE;
					end else begin
						ci_q <= ci_q + 1'b1;
						mv_q <= 1'b0;
					end
				end
				S_FREE: begin
					if (!used_q[free_q]) begin
						if (!used_q[home_q]) begin
							dest_q  <= home_q;
							ci_q    <= '0;
							mv_q    <= 1'b0;
							state_q <= S_PUT;
						end else begin
							dest_q  <= free_q;
							state_q <= S_MOVE;
						end
					end else if (cnt_q == (TW + 1)'(TABLE_SIZE - 1)) begin
						st_q    <= ST_FULL;
						state_q <= S_DONE;
					end else begin
						free_q <= wrap_inc(free_q);
						cnt_q  <= cnt_q + 1'b1;
					end
				end
				S_MOVE: begin
					// header of home read this cycle, checked next pass
					if (!mv_q) begin
						mv_q <= 1'b1;
					end else begin
						mv_q <= 1'b0;
						if (mode_q && hd_home != home_q) begin
							occ_hd_q <= hd_rdata;
							ci_q     <= '0;
							dp_q     <= 1'b1;
							mt_q     <= BUCKET_W'(free_q);
							state_q  <= S_MOVEWR;
						end else begin
							ci_q    <= '0;
							state_q <= S_PUT;
						end
					end
				end
				S_MOVEWR: begin
					// each character's read is primed while mv_q is low and copied while mv_q is high
					if (!mv_q) begin
						mv_q <= 1'b1;
					end else begin
						mv_q <= 1'b0;
						if (ci_q == CW'(MAX_KEY_CHARS - 1)) begin
							used_q[free_q] <= 1'b1;
							dest_q  <= home_q;
							ci_q    <= '0;
							state_q <= S_PUT;
						end else begin
							ci_q <= ci_q + 1'b1;
						end
					end
				end
				S_PUT: begin
					if (!mv_q && klen_q != '0) begin
						mv_q <= 1'b1;
					end else if (klen_q == '0 || last_cmp) begin
						mv_q <= 1'b0;
						used_q[dest_q] <= 1'b1;
						st_q    <= ST_INSERTED;
						bk_q    <= BUCKET_W'(dest_q);
						state_q <= S_DONE;
					end else begin
						mv_q <= 1'b0;
						ci_q <= ci_q + 1'b1;
					end
				end
				S_CLR: begin
					used_q  <= '0;
					st_q    <= ST_CLEARED;
					bk_q    <= '0;
					dp_q    <= 1'b0;
					mt_q    <= '0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					done_q  <= 1'b1;
					klen_q  <= '0;
					ksum_q  <= '0;
					kovf_q  <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done      = done_q;
	assign status    = st_q;
	assign bucket    = bk_q;
	assign displaced = dp_q;
	assign moved_to  = mt_q;
endmodule
`default_nettype wire

>>> hdl/lpsht_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpsht_ram
// Generic simple dual-port RAM with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lpsht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
